>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module lld_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/lld_pkg.sv
// Shared constants and types of the line-line distance block.
// No dependencies.
package lld_pkg;
  localparam int THR_W = 63;
  localparam logic [THR_W-1:0] THR_RESET = 63'd4295;
  localparam int QDEPTH = 16;
  localparam int QADDR_W = $clog2(QDEPTH);
  localparam int QUO_W = 64;
  localparam int ROOT_W = 32;
  localparam int DIST_W = 32;

  typedef struct packed {
    logic par;
    logic deg;
  } lld_flags_t;
endpackage

>>> rtl/core/lld_intf.sv
// Channel interfaces: input line pairs, distance results, threshold writes.
// Depends on lld_pkg.
interface lld_in_if #(parameter int CW = 16) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] a0_x, a0_y, a0_z, a1_x, a1_y, a1_z;
  logic signed [CW-1:0] b0_x, b0_y, b0_z, b1_x, b1_y, b1_z;
  modport source (output valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
                  b0_x, b0_y, b0_z, b1_x, b1_y, b1_z, input ready);
  modport sink (input valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
                b0_x, b0_y, b0_z, b1_x, b1_y, b1_z, output ready);
endinterface

interface lld_out_if import lld_pkg::*; ();
  logic valid;
  logic ready;
  logic [DIST_W-1:0] dist_res;
  logic parallel;
  logic degenerate;
  modport source (output valid, dist_res, parallel, degenerate, input ready);
  modport sink (input valid, dist_res, parallel, degenerate, output ready);
endinterface

interface lld_cfg_if import lld_pkg::*; ();
  logic valid;
  logic ready;
  logic [THR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/lld_front.sv
// Front pipeline: difference vectors, cross products, norms, parallel test.
// Produces numerator, denominator and flags for the divide/root back end.
module lld_front import lld_pkg::*; #(
  parameter int CW  = 16,
  parameter int NNW = 6*CW+12,
  parameter int SQW = 4*CW+6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic signed [CW-1:0] crd [12],
  input  logic [THR_W-1:0]     thr,
  output logic                 push,
  output logic [NNW-1:0]       num,
  output logic [SQW-1:0]       den,
  output lld_flags_t           flags
);
  localparam int EW   = CW+1;
  localparam int PW   = 2*EW;
  localparam int XW   = 2*CW+3;
  localparam int VW   = 2*CW+2;
  localparam int GW   = EW+XW;
  localparam int NW   = 3*CW+6;
  localparam int HW   = (NW+1)/2;
  localparam int LW   = NW-HW;
  localparam int HHW  = 2*LW;
  localparam int LLW  = 2*HW;
  localparam int CMPW = (SQW > THR_W) ? SQW : THR_W;

  logic [7:0] vld_r;

  logic signed [EW-1:0]  v1_r [3], w1_r [3], e1_r [3], e2_r [3], e3_r [3];
  logic signed [PW-1:0]  pa_r [3], pb_r [3], xa_r [3], xb_r [3], vq_r [3];
  logic signed [XW-1:0]  c3_r [3], x3_r [3];
  logic [VW-1:0]         vv3_r, vv4_r, vv5_r, vv6_r;
  logic [SQW-1:0]        cq4_r [3], xq4_r [3];
  logic signed [GW-1:0]  g4_r [3];
  logic [SQW-1:0]        s5_r, xx5_r, s6_r, xx6_r, xx7_r, den7_r, den8_r;
  logic signed [NW-1:0]  dc5_r;
  logic                  par6_r;
  logic [NW-1:0]         n6_r;
  logic [LW-1:0]         hi6;
  logic [HW-1:0]         lo6;
  logic [HHW-1:0]        hh7_r;
  logic [NW-1:0]         hl7_r;
  logic [LLW-1:0]        ll7_r;
  lld_flags_t            fl7_r, fl8_r, fl7_nxt;
  logic [NNW-1:0]        num8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_fire};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int I = (k+1)%3;
    localparam int J = (k+2)%3;
    always_ff @(posedge clk) begin
      v1_r[k]  <= EW'(crd[3+k]) - EW'(crd[k]);
      w1_r[k]  <= EW'(crd[9+k]) - EW'(crd[6+k]);
      e1_r[k]  <= EW'(crd[6+k]) - EW'(crd[k]);
      pa_r[k]  <= PW'(v1_r[I]) * PW'(w1_r[J]);
      pb_r[k]  <= PW'(v1_r[J]) * PW'(w1_r[I]);
      xa_r[k]  <= PW'(e1_r[I]) * PW'(v1_r[J]);
      xb_r[k]  <= PW'(e1_r[J]) * PW'(v1_r[I]);
      vq_r[k]  <= PW'(v1_r[k]) * PW'(v1_r[k]);
      e2_r[k]  <= e1_r[k];
      c3_r[k]  <= XW'(pa_r[k]) - XW'(pb_r[k]);
      x3_r[k]  <= XW'(xa_r[k]) - XW'(xb_r[k]);
      e3_r[k]  <= e2_r[k];
      cq4_r[k] <= $unsigned(SQW'(c3_r[k]) * SQW'(c3_r[k]));
      xq4_r[k] <= $unsigned(SQW'(x3_r[k]) * SQW'(x3_r[k]));
      g4_r[k]  <= GW'(e3_r[k]) * GW'(c3_r[k]);
    end
  end

  assign hi6 = n6_r[NW-1:HW];
  assign lo6 = n6_r[HW-1:0];

  always_comb begin
    fl7_nxt.par = par6_r;
    fl7_nxt.deg = par6_r && (vv6_r == '0);
  end

  always_ff @(posedge clk) begin
    vv3_r  <= VW'($unsigned(vq_r[0])) + VW'($unsigned(vq_r[1])) + VW'($unsigned(vq_r[2]));
    vv4_r  <= vv3_r;
    s5_r   <= cq4_r[0] + cq4_r[1] + cq4_r[2];
    xx5_r  <= xq4_r[0] + xq4_r[1] + xq4_r[2];
    dc5_r  <= NW'(g4_r[0]) + NW'(g4_r[1]) + NW'(g4_r[2]);
    vv5_r  <= vv4_r;
    par6_r <= CMPW'(s5_r) <= CMPW'(thr);
    n6_r   <= dc5_r[NW-1] ? NW'($unsigned(-dc5_r)) : NW'($unsigned(dc5_r));
    s6_r   <= s5_r;
    xx6_r  <= xx5_r;
    vv6_r  <= vv5_r;
    hh7_r  <= HHW'(hi6) * HHW'(hi6);
    hl7_r  <= NW'(hi6) * NW'(lo6);
    ll7_r  <= LLW'(lo6) * LLW'(lo6);
    xx7_r  <= xx6_r;
    fl7_r  <= fl7_nxt;
    if (fl7_nxt.deg) begin
      den7_r <= SQW'(1);
    end else if (par6_r) begin
      den7_r <= SQW'(vv6_r);
    end else begin
      den7_r <= s6_r;
    end
    if (fl7_r.par) begin
      num8_r <= NNW'(xx7_r);
    end else begin
      num8_r <= (NNW'(hh7_r) << (2*HW)) + (NNW'(hl7_r) << (HW+1)) + NNW'(ll7_r);
    end
    den8_r <= den7_r;
    fl8_r  <= fl7_r;
  end

  assign push  = vld_r[7];
  assign num   = num8_r;
  assign den   = den8_r;
  assign flags = fl8_r;
endmodule

>>> rtl/core/lld_queue.sv
// Short FIFO between the front pipeline and the divide/root back end.
// Registered output stage; depends on lld_pkg for its depth.
module lld_queue import lld_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  logic [DW-1:0]      mem_r [QDEPTH];
  logic [QADDR_W-1:0] wp_r, rp_r;
  logic [QADDR_W:0]   cnt_r;
  logic [DW-1:0]      rdata_r;
  logic               ovld_r;
  logic               load, mem_wr, mem_rd;

  // output register takes the next entry when empty or when popped
  assign load   = !ovld_r || pop;
  assign mem_rd = load && (cnt_r != '0);
  assign mem_wr = push && !(load && (cnt_r == '0));

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rdata_r <= mem_r[rp_r];
    end else if (load && push) begin
      rdata_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (mem_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (mem_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      unique case ({mem_wr, mem_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
      if (load) begin
        ovld_r <= (cnt_r != '0) || push;
      end
    end
  end

  assign rdata = rdata_r;
  assign empty = !ovld_r;
endmodule

>>> rtl/core/lld_back.sv
// Back pipeline: restoring divide of num*2^SH by den, then integer square root.
// Depends on lld_pkg. One stage per quotient bit and per root bit.
module lld_back import lld_pkg::*; #(
  parameter int NNW  = 108,
  parameter int DENW = 70,
  parameter int SH   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [NNW-1:0]    q_num,
  input  logic [DENW-1:0]   q_den,
  input  lld_flags_t        q_flags,
  output logic              q_pop,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_dist,
  output lld_flags_t        out_flags
);
  localparam int MW  = (NNW+SH > QUO_W) ? NNW+SH : QUO_W+1;
  localparam int HIW = MW-QUO_W;
  localparam int RW  = DENW+1;
  localparam int ZW  = (HIW > RW) ? HIW : RW;
  localparam int SRW = ROOT_W+3;
  localparam int TOT = QUO_W+ROOT_W;

  logic en;
  logic [MW-1:0] m_in;

  logic       vld_r [0:TOT];
  logic       sat_r [0:TOT];
  lld_flags_t fl_r  [0:TOT];

  logic [RW-1:0]     rem_r [0:QUO_W-1];
  logic [QUO_W-1:0]  lo_r  [0:QUO_W-1];
  logic [DENW-1:0]   den_r [0:QUO_W-1];
  logic [QUO_W-1:0]  quo_r [0:QUO_W];
  logic [QUO_W-1:0]  xs_r  [1:ROOT_W-1];
  logic [SRW-1:0]    rr_r  [1:ROOT_W-1];
  logic [ROOT_W-1:0] rt_r  [1:ROOT_W];

  assign en    = !vld_r[TOT] || out_ready;
  assign q_pop = en && !q_empty;
  assign m_in  = MW'(q_num) << SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= TOT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= q_pop;
      for (int i = 1; i <= TOT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= ZW'(m_in[MW-1:QUO_W]) >= ZW'(q_den);
      fl_r[0]  <= q_flags;
      for (int i = 1; i <= TOT; i++) begin
        sat_r[i] <= sat_r[i-1];
        fl_r[i]  <= fl_r[i-1];
      end
      rem_r[0] <= RW'(m_in[MW-1:QUO_W]);
      lo_r[0]  <= m_in[QUO_W-1:0];
      den_r[0] <= q_den;
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_r[k-1][RW-2:0], lo_r[k-1][QUO_W-1]};
    assign ge = sh >= RW'(den_r[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_r[k-1][QUO_W-2:0], ge};
      end
    end
    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? sh - RW'(den_r[k-1]) : sh;
          lo_r[k]  <= lo_r[k-1] << 1;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_root
    logic [QUO_W-1:0]  x_in;
    logic [ROOT_W-1:0] rt_in;
    logic [SRW-1:0]    rr_in;
    logic [SRW-1:0]    rs;
    logic [SRW-1:0]    trial;
    logic              ge;
    if (j == 1) begin : g_first
      assign x_in  = quo_r[QUO_W];
      assign rt_in = '0;
      assign rr_in = '0;
    end else begin : g_next
      assign x_in  = xs_r[j-1];
      assign rt_in = rt_r[j-1];
      assign rr_in = rr_r[j-1];
    end
    assign rs    = {rr_in[SRW-3:0], x_in[QUO_W-1:QUO_W-2]};
    assign trial = SRW'({rt_in, 2'b01});
    assign ge    = rs >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[j] <= {rt_in[ROOT_W-2:0], ge};
      end
    end
    if (j < ROOT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rr_r[j] <= ge ? rs - trial : rs;
          xs_r[j] <= x_in << 2;
        end
      end
    end
  end

  assign out_valid = vld_r[TOT];
  assign out_dist  = sat_r[TOT] ? '1 : rt_r[ROOT_W];
  assign out_flags = fl_r[TOT];
endmodule

>>> rtl/core/line_line_distance_3d.sv
// Top level of the 3D line-line distance block: front pipeline, queue, back end.
// Depends on lld_pkg, lld_intf, lld_front, lld_queue, lld_back.
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | a0..b1 x/y/z, signed Q8.8
//   out_ch  | out | valid/ready | dist_res Q16.16, parallel, degenerate
//   cfg_ch  | in  | valid/ready | data = parallel_threshold (63 bits)
//
// One transfer per cycle in and out when the result side keeps ready high.
// Pipeline stages: 8 front stages, the queue output register, one back end
// input stage, one divider stage per quotient bit (64) and one root stage per
// result bit (32).
// in_ch.ready drops once 16 items sit in the front and queue; out_ch stalls
// freeze the back end only. cfg_ch.ready is always high.
// rst_n is synchronous; no clearing pass is needed.
module line_line_distance_3d import lld_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input logic       clk,
  input logic       rst_n,
  lld_in_if.sink    in_ch,
  lld_out_if.source out_ch,
  lld_cfg_if.sink   cfg_ch
);
  localparam int NNW = 6*COORD_WIDTH+12;
  localparam int SQW = 4*COORD_WIDTH+6;
  localparam int SH  = 32-2*FRAC_BITS;
  localparam int QW  = 2+NNW+SQW;

  logic [THR_W-1:0]  thr_r;
  logic [QADDR_W:0]  cnt_r;
  logic              in_rdy, in_fire, q_pop, q_empty, f_push;
  logic signed [COORD_WIDTH-1:0] crd [12];
  logic [NNW-1:0]    f_num, q_num;
  logic [SQW-1:0]    f_den, q_den;
  lld_flags_t        f_flags, q_flags, o_flags;
  logic [QW-1:0]     q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  assign in_rdy      = cnt_r < (QADDR_W+1)'(QDEPTH);
  assign in_ch.ready = in_rdy;
  assign in_fire     = in_ch.valid && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case ({in_fire, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign crd[0]  = in_ch.a0_x;
  assign crd[1]  = in_ch.a0_y;
  assign crd[2]  = in_ch.a0_z;
  assign crd[3]  = in_ch.a1_x;
  assign crd[4]  = in_ch.a1_y;
  assign crd[5]  = in_ch.a1_z;
  assign crd[6]  = in_ch.b0_x;
  assign crd[7]  = in_ch.b0_y;
  assign crd[8]  = in_ch.b0_z;
  assign crd[9]  = in_ch.b1_x;
  assign crd[10] = in_ch.b1_y;
  assign crd[11] = in_ch.b1_z;

  lld_front #(.CW(COORD_WIDTH), .NNW(NNW), .SQW(SQW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .crd     (crd),
    .thr     (thr_r),
    .push    (f_push),
    .num     (f_num),
    .den     (f_den),
    .flags   (f_flags)
  );

  lld_queue #(.DW(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_flags, f_num, f_den}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_flags = q_rdata[QW-1:QW-2];
  assign q_num   = q_rdata[NNW+SQW-1:SQW];
  assign q_den   = q_rdata[SQW-1:0];

  lld_back #(.NNW(NNW), .DENW(SQW), .SH(SH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_num     (q_num),
    .q_den     (q_den),
    .q_flags   (q_flags),
    .q_pop     (q_pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_dist  (out_ch.dist_res),
    .out_flags (o_flags)
  );

  assign out_ch.parallel   = o_flags.par;
  assign out_ch.degenerate = o_flags.deg;
endmodule

>>> rtl/core/lld_checker.sv
// Port-level checker for line_line_distance_3d, with its bind.
// Depends on lld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lld_checker import lld_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] dist_res,
  input logic              par,
  input logic              deg
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(dist_res))
  `ASSERT_IMPLY(a_deg_par, clk, rst_n, out_valid && deg, par)
  `ASSERT_IMPLY(a_deg_zero, clk, rst_n, out_valid && deg, dist_res == '0)
endmodule

bind line_line_distance_3d lld_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .dist_res  (out_ch.dist_res),
  .par       (out_ch.parallel),
  .deg       (out_ch.degenerate)
);
